FILE: src/tlc_pkg.sv
// Shared types, codes and helpers for the two-way traffic light controller.
// No dependencies; imported by tlc_step and the top level.
package tlc_pkg;

	localparam int unsigned MAX_SECONDS = 99;

	// top_mode codes
	localparam logic [2:0] MODE_START  = 3'd0;
	localparam logic [2:0] MODE_RUN    = 3'd1;
	localparam logic [2:0] MODE_RED    = 3'd2;
	localparam logic [2:0] MODE_GREEN  = 3'd3;
	localparam logic [2:0] MODE_YELLOW = 3'd4;

	// light phase codes
	localparam logic [1:0] PH_LOAD   = 2'd0;
	localparam logic [1:0] PH_RED    = 2'd1;
	localparam logic [1:0] PH_GREEN  = 2'd2;
	localparam logic [1:0] PH_YELLOW = 2'd3;

	// expiry flag bits
	localparam int unsigned FLG_SEC   = 2;
	localparam int unsigned FLG_BLINK = 3;

	typedef struct packed {
		logic [2:0]        top_mode;
		logic [1:0]        first_phase;
		logic [1:0]        second_phase;
		logic [2:0][6:0]   phase_sec;
		logic [2:0][6:0]   pend_sec;
		logic [3:0][3:0]   digits;
		logic [1:0][16:0]  phase_cnt;
		logic [9:0]        sec_cnt;
		logic [7:0]        blink_cnt;
		logic [3:0]        flags;
		logic              blink;
		logic [5:0]        lamps;
	} tlc_state_t;

	localparam tlc_state_t ST_RESET = '{
		top_mode:     MODE_START,
		first_phase:  PH_LOAD,
		second_phase: PH_LOAD,
		phase_sec:    {7'd2, 7'd3, 7'd5},
		pend_sec:     {7'd2, 7'd3, 7'd5},
		digits:       '0,
		phase_cnt:    '0,
		sec_cnt:      '0,
		blink_cnt:    '0,
		flags:        4'b1100,
		blink:        1'b0,
		lamps:        6'h3F
	};

	// Tens of a 7-bit value: multiply by 205/2048, exact below 1029.
	function automatic logic [3:0] div10(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [3:0] mod10(input logic [6:0] v);
		logic [6:0] q10;
		q10 = 7'(div10(v)) * 7'd10;
		return 4'(v - q10);
	endfunction

endpackage

FILE: src/tlc_step.sv
// Next-state logic for one timebase tick of the traffic light controller.
// Depends on tlc_pkg (state struct, mode and phase codes, digit helpers).
module tlc_step import tlc_pkg::*; (
	input  tlc_state_t cur,
	input  logic [9:0] tps,
	input  logic       mode_press,
	input  logic       inc_press,
	input  logic       commit_press,
	output tlc_state_t nxt
);

	function automatic tlc_state_t load_phase(input tlc_state_t st, input logic lt,
			input logic [1:0] colour, input logic [9:0] t);
		logic [6:0] s;
		s = st.phase_sec[colour];
		st.phase_cnt[lt] = 17'(s) * 17'(t);
		st.flags[lt] = 1'b0;
		st.digits[{lt, 1'b0}] = div10(s);
		st.digits[{lt, 1'b1}] = mod10(s) + 4'd1;
		return st;
	endfunction

	function automatic tlc_state_t run_light(input tlc_state_t st, input logic lt,
			input logic [1:0] first, input logic [9:0] t);
		logic [1:0] p;
		logic [1:0] n;
		logic [2:0] grp;
		p = lt ? st.second_phase : st.first_phase;
		if (p == PH_LOAD) begin
			if (lt) st.second_phase = first;
			else st.first_phase = first;
			st = load_phase(st, lt, first - 2'd1, t);
		end else begin
			grp = 3'b111;
			grp[p - 2'd1] = 1'b0;
			if (lt) st.lamps[5:3] = grp;
			else st.lamps[2:0] = grp;
			if (st.flags[lt]) begin
				n = (p == PH_YELLOW) ? PH_RED : p + 2'd1;
				if (lt) st.second_phase = n;
				else st.first_phase = n;
				st = load_phase(st, lt, n - 2'd1, t);
			end
		end
		return st;
	endfunction

	// Units at zero wrap to nine and borrow from tens, tens hold at zero.
	function automatic tlc_state_t count_down(input tlc_state_t st, input logic h);
		if (st.digits[{h, 1'b1}] == 4'd0) begin
			st.digits[{h, 1'b1}] = 4'd9;
			if (st.digits[{h, 1'b0}] != 4'd0)
				st.digits[{h, 1'b0}] = st.digits[{h, 1'b0}] - 4'd1;
		end else begin
			st.digits[{h, 1'b1}] = st.digits[{h, 1'b1}] - 4'd1;
		end
		return st;
	endfunction

	function automatic tlc_state_t run_edit(input tlc_state_t st, input logic [1:0] colour,
			input logic inc, input logic com, input logic [9:0] t);
		logic [5:0] v;
		logic [6:0] pv;
		if (st.flags[FLG_BLINK]) begin
			v = 6'h3F;
			if (!st.blink) begin
				v[colour] = 1'b0;
				v[3'(colour) + 3'd3] = 1'b0;
			end
			st.lamps = v;
			st.blink = ~st.blink;
			st.blink_cnt = t[9:2];
			st.flags[FLG_BLINK] = 1'b0;
		end
		if (inc) begin
			pv = st.pend_sec[colour] + 7'd1;
			if (pv > 7'(MAX_SECONDS)) pv = '0;
			st.pend_sec[colour] = pv;
		end
		if (com) st.phase_sec[colour] = st.pend_sec[colour];
		return st;
	endfunction

	function automatic tlc_state_t show_edit(input tlc_state_t st, input logic [1:0] colour);
		st.digits[0] = div10(st.pend_sec[colour]);
		st.digits[1] = mod10(st.pend_sec[colour]);
		st.digits[2] = 4'd0;
		st.digits[3] = 4'(colour) + 4'd2;
		return st;
	endfunction

	always_comb begin
		tlc_state_t st;
		logic [1:0] c;
		st = cur;
		c  = 2'(cur.top_mode - MODE_RED);
		unique case (cur.top_mode)
			MODE_START: begin
				st.top_mode = MODE_RUN;
				st.first_phase = PH_LOAD;
			end
			MODE_RUN: begin
				st = run_light(st, 1'b0, PH_RED, tps);
				st = run_light(st, 1'b1, PH_GREEN, tps);
				if (st.flags[FLG_SEC]) begin
					st = count_down(st, 1'b0);
					st = count_down(st, 1'b1);
					st.sec_cnt = tps;
					st.flags[FLG_SEC] = 1'b0;
				end
				if (mode_press) begin
					st.top_mode = MODE_RED;
					st = run_edit(st, 2'd0, inc_press, commit_press, tps);
					st = show_edit(st, 2'd0);
				end
			end
			MODE_RED, MODE_GREEN: begin
				st = run_edit(st, c, inc_press, commit_press, tps);
				st = show_edit(st, c);
				if (mode_press) begin
					// drop the uncommitted value, move to the next colour
					st.pend_sec[c] = st.phase_sec[c];
					st.top_mode = cur.top_mode + 3'd1;
					st = run_edit(st, c + 2'd1, 1'b0, 1'b0, tps);
					st = show_edit(st, c + 2'd1);
				end
			end
			MODE_YELLOW: begin
				st = run_edit(st, 2'd2, inc_press, commit_press, tps);
				st = show_edit(st, 2'd2);
				if (mode_press) begin
					st.pend_sec[2] = st.phase_sec[2];
					st.top_mode = MODE_RUN;
					st.first_phase = PH_LOAD;
					st.second_phase = PH_LOAD;
				end
			end
			default: begin
			end
		endcase

		// counters advance after the control logic; a zero load never expires
		for (int k = 0; k < 2; k++) begin
			if (st.phase_cnt[k] != '0) begin
				st.phase_cnt[k] = st.phase_cnt[k] - 17'd1;
				if (st.phase_cnt[k] == '0) st.flags[k] = 1'b1;
			end
		end
		if (st.sec_cnt != '0) begin
			st.sec_cnt = st.sec_cnt - 10'd1;
			if (st.sec_cnt == '0) st.flags[FLG_SEC] = 1'b1;
		end
		if (st.blink_cnt != '0) begin
			st.blink_cnt = st.blink_cnt - 8'd1;
			if (st.blink_cnt == '0) st.flags[FLG_BLINK] = 1'b1;
		end
		nxt = st;
	end

endmodule

FILE: src/two_way_traffic_light_controller.sv
// Two-way traffic light controller: one timebase tick per input beat.
// Latency: the result beat is valid the cycle after its tick beat is accepted.
// Throughput: one tick per cycle while m_tready is high; the next tick is taken while the result is being taken.
// The state register doubles as the result register; timer loads multiply in the same cycle.
// arst_n clears all state: start mode, lamps off, durations red 5, green 3, yellow 2,
// ticks_per_second 100.
module two_way_traffic_light_controller import tlc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data,      // ticks_per_second
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [0] next_mode_press, [1] increment_press,
	                                   // [2] commit_press, [7:3] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata        // [2:0] first_lamps, [5:3] second_lamps,
	                                   // [9:6] digit_zero, [13:10] digit_one,
	                                   // [17:14] digit_two, [21:18] digit_three,
	                                   // [24:22] active_mode, [31:25] zero
);

	tlc_state_t st_q;
	tlc_state_t st_nxt;
	logic [9:0] tps_q;
	logic       out_valid_q;
	logic       take;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign take      = s_tvalid && s_tready;

	tlc_step u_step (
		.cur          (st_q),
		.tps          (tps_q),
		.mode_press   (s_tdata[0]),
		.inc_press    (s_tdata[1]),
		.commit_press (s_tdata[2]),
		.nxt          (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RESET;
			tps_q       <= 10'd100;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) tps_q <= cfg_data;
			// advance state only when the previous result beat is gone or leaving
			if (take) st_q <= st_nxt;
			if (take) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, st_q.top_mode, st_q.digits[3], st_q.digits[2],
		st_q.digits[1], st_q.digits[0], st_q.lamps[5:3], st_q.lamps[2:0]};

endmodule
